// File: sv/hac_pkg.sv
// Shared constants, request codes and lane control type for the Hopfield recall unit.
package hac_pkg;

	localparam int NEURONS_DEF       = 128;
	localparam int LANES             = 16;
	localparam int WEIGHT_BITS_DEF   = 8;
	localparam int ACTIVE_RESET      = 108;
	localparam int SWEEP_LIMIT_RESET = 100;
	localparam int ENERGY_LIMIT      = 2097152;
	localparam int ENERGY_BITS       = 23;

	typedef enum logic [1:0] {
		REQ_TRAIN = 2'd0,
		REQ_PROBE = 2'd1,
		REQ_CLEAR = 2'd2,
		REQ_NONE  = 2'd3
	} req_t;

	localparam logic REG_ACTIVE = 1'b0;
	localparam logic REG_SWEEPS = 1'b1;

	typedef struct packed {
		logic spin_i;    // row neuron, training only
		logic spin_j;    // column neuron of this lane
		logic in_range;  // column below the active neuron count
		logic diag;      // column equals row
	} lane_ctl_t;

endpackage

// File: sv/hac_wmem.sv
// Weight memory: one row band of lane weights per word, registered read.
module hac_wmem import hac_pkg::*; #(
	parameter int AW = 10,
	parameter int DW = 128
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [1<<AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// File: sv/hac_lane.sv
// One lane: Hebbian weight update and signed product for recall.
module hac_lane import hac_pkg::*; #(
	parameter int WB = 8
) (
	input  lane_ctl_t             ctl,
	input  logic signed [WB-1:0]  w,
	output logic signed [WB-1:0]  w_next,
	output logic signed [WB:0]    prod
);

	localparam logic signed [WB:0] W_TOP = (WB+1)'((1 << (WB-1)) - 1);
	localparam logic signed [WB:0] W_BOT = -W_TOP - (WB+1)'(1);

	logic signed [WB:0] sum;

	always_comb begin
		sum = (ctl.spin_i == ctl.spin_j) ? {w[WB-1], w} + (WB+1)'(1)
		                                 : {w[WB-1], w} - (WB+1)'(1);
		if (!ctl.in_range || ctl.diag) begin
			w_next = w;
		end else if (sum > W_TOP) begin
			w_next = W_TOP[WB-1:0];
		end else if (sum < W_BOT) begin
			w_next = W_BOT[WB-1:0];
		end else begin
			w_next = sum[WB-1:0];
		end

		if (!ctl.in_range) begin
			prod = '0;
		end else if (ctl.spin_j) begin
			prod = {w[WB-1], w};
		end else begin
			prod = -{w[WB-1], w};
		end
	end

endmodule

// File: sv/hac_merge.sv
// Merge stage: sums the lane products of one row band.
module hac_merge import hac_pkg::*; #(
	parameter int PW = 9,
	parameter int OW = 17
) (
	input  logic signed [LANES-1:0][PW-1:0] prod,
	output logic signed [OW-1:0]            sum
);

	logic signed [OW-1:0] half [4];

	always_comb begin
		for (int g = 0; g < 4; g++) begin
			half[g] = OW'($signed(prod[4*g]))   + OW'($signed(prod[4*g+1]))
			        + OW'($signed(prod[4*g+2])) + OW'($signed(prod[4*g+3]));
		end
		sum = (half[0] + half[1]) + (half[2] + half[3]);
	end

endmodule

// File: sv/hopfield_associative_recall_unit.sv
// Top level: Hopfield associative memory with Hebbian training and synchronous recall.
//
// channel  direction  handshake          payload
// cfg      in         cfg_we             cfg_index, cfg_data
// in       in         in_valid/in_stall  req_type, chunk_index, chunk_bits, last_chunk
// out      out        out_valid/out_stall out_index, out_bits, out_last, converged,
//                                        sweeps_done, start_energy, end_energy
//
// Chunks are taken one per cycle while the unit is idle. A pattern's last chunk
// starts training, which updates the n * ceil(n/16) weight row bands one per cycle.
// A recall runs sweeps over the same row bands, plus one energy pass when the sweep
// limit is hit; then the chunks go out one per cycle while out_stall is low.
// After reset and on a clear request the weight memory is wiped, one word a
// cycle, all 2^AW words (1024 by default); items wait.
// in_stall is high throughout training, recall, wiping and output.
module hopfield_associative_recall_unit import hac_pkg::*; #(
	parameter int NEURONS     = NEURONS_DEF,
	parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic                           cfg_index,
	input  logic [7:0]                     cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [1:0]                     req_type,
	input  logic [2:0]                     chunk_index,
	input  logic [15:0]                    chunk_bits,
	input  logic                           last_chunk,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [2:0]                     out_index,
	output logic [15:0]                    out_bits,
	output logic                           out_last,
	output logic                           converged,
	output logic [7:0]                     sweeps_done,
	output logic signed [ENERGY_BITS-1:0]  start_energy,
	output logic signed [ENERGY_BITS-1:0]  end_energy
);

	localparam int CHUNKS = NEURONS / LANES;
	localparam int CW     = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
	localparam int IW     = $clog2(NEURONS);
	localparam int AW     = IW + CW;
	localparam int NW     = $clog2(NEURONS + 1);
	localparam int WB     = WEIGHT_BITS;
	localparam int PW     = WB + 1;
	localparam int HW     = WB + IW + 2;
	localparam int EW     = (HW + IW + 1 > 24) ? HW + IW + 1 : 24;
	localparam int KW     = CW + 1;

	localparam logic signed [EW-1:0] E_HI = EW'(ENERGY_LIMIT);
	localparam logic signed [EW-1:0] E_LO = -E_HI;

	typedef enum logic [2:0] {
		ST_CLEAR, ST_IDLE, ST_TRAIN, ST_PREP, ST_SWEEP, ST_ENERGY, ST_EMIT
	} state_t;

	state_t state_q;
	logic [7:0]    active_q, maxit_q, sweeps_q;
	logic [AW-1:0] clr_q;
	logic [IW-1:0] i_q;
	logic [CW-1:0] c_q;
	logic          iss_q, eonly_q;
	logic          v_s1, v_s2, v_s3;
	logic [KW-1:0] k_q;
	logic          out_valid_q;

	logic [CHUNKS-1:0][LANES-1:0] pat_q, cur_q, prv_q;

	logic [IW-1:0] i_s1, i_s2, i_s3;
	logic [CW-1:0] c_s1;
	logic          re_s1, re_s2;
	logic signed [LANES-1:0][PW-1:0] prod_s2;
	logic signed [HW-1:0] acc_q, h_s3;
	logic signed [EW-1:0] eng_q;
	logic signed [ENERGY_BITS-1:0] e0_q, e1_q;
	logic          same_q;

	logic [NW-1:0] n;
	logic [NW-1:0] nch;
	logic [7:0]    limit;
	logic          in_fire, busy, pass_done, last_c, last_i, same_now, load_out;
	logic [CW-1:0] cidx;
	logic          cidx_ok;
	logic signed [EW-1:0] eng_sat;
	logic [15:0]   out_mask;

	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [LANES*WB-1:0] wr_data, rd_data, upd_data;
	logic signed [LANES-1:0][PW-1:0] prod;
	logic signed [HW-1:0] band_sum;
	logic signed [HW-1:0] acc_sum;

	always_comb begin
		if (active_q == 8'd0) begin
			n = NW'(1);
		end else if (int'(active_q) > NEURONS) begin
			n = NW'(NEURONS);
		end else begin
			n = NW'(active_q);
		end
		nch       = (n + NW'(LANES - 1)) >> 4;
		limit     = (maxit_q == 8'd0) ? 8'd1 : maxit_q;
		in_fire   = in_valid && !in_stall;
		busy      = v_s1 || v_s2 || v_s3;
		pass_done = !iss_q && !busy;
		last_c    = int'(c_q) == int'(nch) - 1;
		last_i    = int'(i_q) == int'(n) - 1;
		same_now  = cur_q == prv_q;
		cidx      = CW'(chunk_index);
		cidx_ok   = int'(chunk_index) < CHUNKS;
		if (eng_q > E_HI) begin
			eng_sat = E_HI;
		end else if (eng_q < E_LO) begin
			eng_sat = E_LO;
		end else begin
			eng_sat = eng_q;
		end
		if (int'(n) - int'(k_q) * LANES >= LANES) begin
			out_mask = 16'hFFFF;
		end else begin
			out_mask = 16'((32'd1 << (int'(n) - int'(k_q) * LANES)) - 32'd1);
		end
		load_out = (state_q == ST_EMIT) && (!out_valid_q || !out_stall) && (k_q < KW'(nch));
		acc_sum  = acc_q + band_sum;
	end

	assign in_stall = state_q != ST_IDLE;
	assign out_valid = out_valid_q;

	// weight memory and lanes
	always_comb begin
		if (state_q == ST_CLEAR) begin
			wr_en   = 1'b1;
			wr_addr = clr_q;
			wr_data = '0;
		end else begin
			wr_en   = v_s1 && (state_q == ST_TRAIN);
			wr_addr = {i_s1, c_s1};
			wr_data = upd_data;
		end
	end

	hac_wmem #(.AW(AW), .DW(LANES*WB)) u_wmem (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.raddr ({i_q, c_q}),
		.rdata (rd_data)
	);

	for (genvar l = 0; l < LANES; l++) begin : g_lane
		lane_ctl_t ctl;
		logic [CW+3:0] j;
		always_comb begin
			j            = {c_s1, 4'(l)};
			ctl.in_range = int'(j) < int'(n);
			ctl.diag     = int'(j) == int'(i_s1);
			ctl.spin_i   = pat_q[CW'(i_s1 >> 4)][i_s1[3:0]];
			ctl.spin_j   = (state_q == ST_TRAIN) ? pat_q[c_s1][l] : prv_q[c_s1][l];
		end
		hac_lane #(.WB(WB)) u_lane (
			.ctl    (ctl),
			.w      (rd_data[l*WB +: WB]),
			.w_next (upd_data[l*WB +: WB]),
			.prod   (prod[l])
		);
	end

	hac_merge #(.PW(PW), .OW(HW)) u_merge (
		.prod (prod_s2),
		.sum  (band_sum)
	);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			active_q    <= 8'(ACTIVE_RESET);
			maxit_q     <= 8'(SWEEP_LIMIT_RESET);
			sweeps_q    <= '0;
			clr_q       <= '0;
			i_q         <= '0;
			c_q         <= '0;
			iss_q       <= 1'b0;
			eonly_q     <= 1'b0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_ACTIVE: active_q <= cfg_data;
					REG_SWEEPS: maxit_q  <= cfg_data;
					default:    ;
				endcase
			end
			v_s1 <= iss_q;
			v_s2 <= v_s1 && (state_q != ST_TRAIN);
			v_s3 <= v_s2 && re_s2;
			if (iss_q) begin
				if (last_c) begin
					c_q <= '0;
					if (last_i) begin
						iss_q <= 1'b0;
					end else begin
						i_q <= i_q + IW'(1);
					end
				end else begin
					c_q <= c_q + CW'(1);
				end
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == {AW{1'b1}}) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_fire) begin
						unique case (req_t'(req_type))
							REQ_TRAIN: if (last_chunk) begin
								state_q <= ST_TRAIN;
								iss_q   <= 1'b1;
								i_q     <= '0;
								c_q     <= '0;
							end
							REQ_PROBE: if (last_chunk) begin
								state_q  <= ST_PREP;
								eonly_q  <= 1'b0;
								sweeps_q <= '0;
							end
							REQ_CLEAR: begin
								state_q <= ST_CLEAR;
								clr_q   <= '0;
							end
							REQ_NONE: ;
							default: ;
						endcase
					end
				end
				ST_TRAIN: begin
					if (pass_done) begin
						state_q <= ST_IDLE;
					end
				end
				ST_PREP: begin
					state_q <= eonly_q ? ST_ENERGY : ST_SWEEP;
					iss_q   <= 1'b1;
					i_q     <= '0;
					c_q     <= '0;
				end
				ST_SWEEP: begin
					if (pass_done) begin
						sweeps_q <= sweeps_q + 8'd1;
						if (same_now) begin
							state_q <= ST_EMIT;
							k_q     <= '0;
						end else begin
							state_q <= ST_PREP;
							eonly_q <= (sweeps_q + 8'd1) >= limit;
						end
					end
				end
				ST_ENERGY: begin
					if (pass_done) begin
						state_q <= ST_EMIT;
						k_q     <= '0;
					end
				end
				ST_EMIT: begin
					if (load_out) begin
						out_valid_q <= 1'b1;
						k_q         <= k_q + KW'(1);
					end else if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_fire && cidx_ok) begin
			if (req_type == REQ_TRAIN) begin
				pat_q[cidx] <= chunk_bits;
			end else if (req_type == REQ_PROBE) begin
				cur_q[cidx] <= chunk_bits;
			end
		end

		i_s1    <= i_q;
		c_s1    <= c_q;
		re_s1   <= last_c;
		i_s2    <= i_s1;
		re_s2   <= re_s1;
		prod_s2 <= prod;
		i_s3    <= i_s2;
		h_s3    <= acc_sum;

		if (state_q == ST_PREP) begin
			prv_q <= cur_q;
			acc_q <= '0;
			eng_q <= '0;
		end else begin
			if (v_s2) begin
				acc_q <= re_s2 ? '0 : acc_sum;
			end
			if (v_s3) begin
				// accumulate -s_i * h_i
				if (prv_q[CW'(i_s3 >> 4)][i_s3[3:0]]) begin
					eng_q <= eng_q - EW'(h_s3);
				end else begin
					eng_q <= eng_q + EW'(h_s3);
				end
				if (state_q == ST_SWEEP && h_s3 != '0) begin
					cur_q[CW'(i_s3 >> 4)][i_s3[3:0]] <= !h_s3[HW-1];
				end
			end
		end

		if (state_q == ST_SWEEP && pass_done) begin
			same_q <= same_now;
			if (sweeps_q == 8'd0) begin
				e0_q <= eng_sat[ENERGY_BITS-1:0];
			end
			if (same_now) begin
				e1_q <= eng_sat[ENERGY_BITS-1:0];
			end
		end
		if (state_q == ST_ENERGY && pass_done) begin
			e1_q <= eng_sat[ENERGY_BITS-1:0];
		end

		if (load_out) begin
			out_index    <= 3'(k_q);
			out_bits     <= cur_q[CW'(k_q)] & out_mask;
			out_last     <= k_q == KW'(nch - NW'(1));
			converged    <= same_q;
			sweeps_done  <= sweeps_q;
			start_energy <= e0_q;
			end_energy   <= e1_q;
		end
	end

endmodule

// File: sv/hac_checker.sv
// Port-level checks for the Hopfield recall unit, bound to the top level.
module hac_checker import hac_pkg::*; (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          cfg_we,
	input logic                          cfg_index,
	input logic [7:0]                    cfg_data,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic [1:0]                    req_type,
	input logic [2:0]                    chunk_index,
	input logic [15:0]                   chunk_bits,
	input logic                          last_chunk,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [2:0]                    out_index,
	input logic [15:0]                   out_bits,
	input logic                          out_last,
	input logic                          converged,
	input logic [7:0]                    sweeps_done,
	input logic signed [ENERGY_BITS-1:0] start_energy,
	input logic signed [ENERGY_BITS-1:0] end_energy
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_bits) && $stable(out_index))
		else $error("stalled item changed");

	a_no_input_during_output: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input taken while results pending");

	a_last_ends_burst: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && out_last |=> !out_valid)
		else $error("item after last chunk");

	a_sweep_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> sweeps_done != 8'd0)
		else $error("result with no sweep");

endmodule

bind hopfield_associative_recall_unit hac_checker u_hac_checker (.*);
